### design/fmenc_pkg.sv
// Shared types and constants for the FM/MFM byte encoder with CRC.
package fmenc_pkg;

    // Input item codes
    localparam logic [1:0] ACT_DATA = 2'd0;
    localparam logic [1:0] ACT_MARK = 2'd1;
    localparam logic [1:0] ACT_CRC  = 2'd2;
    // Unused code: the item is dropped with no effect
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Encoding mode register values
    localparam logic MODE_FM  = 1'b0;
    localparam logic MODE_MFM = 1'b1;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_RESET = 16'hFFFF;
    localparam logic [15:0] CRC_SPOIL = 16'h5555;

    localparam logic [5:0] CELLS_FM  = 6'd32;
    localparam logic [5:0] CELLS_MFM = 6'd16;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [7:0]  clock_byte;
        logic        crc_load;
        logic [15:0] crc_seed;
        logic        crc_update;
        logic        corrupt_crc;
    } t_in_item;

    typedef struct packed {
        logic [31:0] cells;
        logic [5:0]  cell_count;
        logic        last_of_item;
    } t_out_item;

    // One byte to expand into cells, as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] clk;
        logic       expl;
        logic       last;
    } t_byte_op;

endpackage

### design/fmenc_front.sv
// Front end: accepts items, keeps the running CRC and queues byte operations.
module fmenc_front
    import fmenc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    output logic     o_push,
    output t_byte_op o_op,
    input  logic     i_space
);

    logic [15:0] r_crc, n_crc;
    logic        r_pend, n_pend;
    logic [7:0]  r_pend_byte, n_pend_byte;
    logic        w_accept;
    logic [15:0] w_base;
    logic [15:0] w_out;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign o_in_ready = !r_pend && i_space;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_base     = i_in.crc_load ? i_in.crc_seed : r_crc;
    assign w_out      = w_base ^ (i_in.corrupt_crc ? CRC_SPOIL : 16'h0000);

    always_comb begin
        n_crc       = r_crc;
        n_pend      = r_pend;
        n_pend_byte = r_pend_byte;
        o_push      = 1'b0;
        o_op        = '0;
        if (r_pend) begin
            // second CRC byte waits for room in the queue
            o_op.data = r_pend_byte;
            o_op.last = 1'b1;
            if (i_space) begin
                o_push = 1'b1;
                n_pend = 1'b0;
            end
        end else if (w_accept && i_in.action != ACT_NONE) begin
            o_push = 1'b1;
            if (i_in.action == ACT_CRC) begin
                n_crc       = w_base;
                o_op.data   = w_out[15:8];
                n_pend      = 1'b1;
                n_pend_byte = w_out[7:0];
            end else begin
                n_crc     = i_in.crc_update ? crc_fold(w_base, i_in.data_byte) : w_base;
                o_op.data = i_in.data_byte;
                o_op.clk  = i_in.clock_byte;
                o_op.expl = (i_in.action == ACT_MARK);
                o_op.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_RESET;
            r_pend <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_pend <= n_pend;
        end
        r_pend_byte <= n_pend_byte;
    end

endmodule

### design/fmenc_fifo.sv
// Two-entry queue of byte operations between front and back.
module fmenc_fifo
    import fmenc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_byte_op i_op,
    output logic     o_space,
    output logic     o_valid,
    output t_byte_op o_op,
    input  logic     i_pop
);

    t_byte_op   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wr_ptr] <= i_op;
    end

endmodule

### design/fmenc_back.sv
// Back end: expands queued bytes into FM or MFM flux cells.
module fmenc_back
    import fmenc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mode,
    input  logic      i_op_valid,
    input  t_byte_op  i_op,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic      r_prev;
    logic      r_valid;
    t_out_item r_out, n_out;
    logic [7:0] w_clk;
    logic [8:0] w_bits;

    assign o_pop       = i_op_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;
    // Data bits with the previous byte's last bit above the MSB
    assign w_bits      = {r_prev, i_op.data};

    always_comb begin
        n_out = '0;
        for (int i = 0; i < 8; i++) begin
            if (i_op.expl)
                w_clk[i] = i_op.clk[i];
            else if (i_mode == MODE_FM)
                w_clk[i] = 1'b1;
            else
                w_clk[i] = !w_bits[i+1] && !w_bits[i];
        end
        for (int i = 0; i < 8; i++) begin
            if (i_mode == MODE_FM) begin
                n_out.cells[4*i+3] = w_clk[i];
                n_out.cells[4*i+1] = i_op.data[i];
            end else begin
                n_out.cells[2*i+1] = w_clk[i];
                n_out.cells[2*i]   = i_op.data[i];
            end
        end
        n_out.cell_count   = (i_mode == MODE_FM) ? CELLS_FM : CELLS_MFM;
        n_out.last_of_item = i_op.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_prev  <= i_op.data[0];
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) r_out <= n_out;
    end

endmodule

### design/fm_mfm_byte_encoder_with_crc.sv
// Top level of the FM/MFM floppy write encoder with running CRC-16.
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  -----------------------
//   input     in         i_in_valid / o_in_ready      i_in  (t_in_item)
//   result    out        o_out_valid / i_out_ready    o_out (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (encoding mode)
//
// A data or mark byte yields one result; the front end runs one byte per cycle
// while the queue has room. A CRC item yields two results and holds the input
// off while the front end queues the low byte. A result passes through the queue,
// written at the transfer, and then the output register. Reset (synchronous,
// active low) empties the queue and the output register, loads the CRC with all
// ones and selects MFM. A stall on the result side fills the two-entry queue
// and only then drops input ready.
module fm_mfm_byte_encoder_with_crc
    import fmenc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic     r_mode;
    logic     w_push;
    t_byte_op w_push_op;
    logic     w_space;
    logic     w_q_valid;
    t_byte_op w_q_op;
    logic     w_pop;

    // Configuration is always accepted; the user must write it only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MFM;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Front: classify items, update the CRC, queue bytes to encode
    fmenc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_push     (w_push),
        .o_op       (w_push_op),
        .i_space    (w_space)
    );

    // Decouple front and back so each side stalls on its own
    fmenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_pop)
    );

    // Back: expand bytes to flux cells into the output register
    fmenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_op_valid  (w_q_valid),
        .i_op        (w_q_op),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### bench/tb_top.sv
// Self-checking bench for the FM/MFM byte encoder: directed marks and CRC cases, then random records.
module tb_top;
    import fmenc_pkg::*;

    // Run limit, generous against the slowest legal run
    localparam int RUN_LIMIT = 2_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    // Shadow of the block state: encoding mode, running CRC, last data bit
    logic        mode_reg;
    logic [15:0] crc_state;
    logic        prev_data_bit;

    // Cell words still owed by the block, oldest first
    t_out_item cell_words_due[$];

    int  mismatch_count = 0;
    int  real_sent = 0;
    // Suppress idling on both sides while set
    bit  calm = 1'b0;

    fm_mfm_byte_encoder_with_crc DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fold one byte into a CRC-16 CCITT, MSB first
    function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] c, logic [7:0] b);
        int i;
        c = c ^ {b, 8'h00};
        for (i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Expand one byte into flux cells; advance the last data bit
    function automatic t_out_item expand_cells(logic [7:0] d, logic [7:0] c, logic expl,
                                               logic last);
        t_out_item   w;
        logic [31:0] acc;
        logic        fm;
        logic        cb;
        int          i;
        fm  = (mode_reg == MODE_FM);
        acc = '0;
        for (i = 7; i >= 0; i--) begin
            if (expl)
                cb = c[i];
            else if (fm)
                cb = 1'b1;
            else
                cb = !prev_data_bit && !d[i];
            // In FM each cell is followed by a zero cell
            acc = fm ? {acc[29:0], cb, 1'b0} : {acc[30:0], cb};
            acc = fm ? {acc[29:0], d[i], 1'b0} : {acc[30:0], d[i]};
            prev_data_bit = d[i];
        end
        w.cells        = acc;
        w.cell_count   = fm ? CELLS_FM : CELLS_MFM;
        w.last_of_item = last;
        return w;
    endfunction

    // Queue the cell words that one accepted item must produce
    task automatic predict_cells(t_in_item it);
        logic [15:0] v;
        if (it.action == ACT_NONE)
            return;
        if (it.crc_load)
            crc_state = it.crc_seed;
        if (it.action == ACT_CRC) begin
            // Emit both CRC bytes as plain data; leave the CRC alone
            v = crc_state ^ (it.corrupt_crc ? CRC_SPOIL : 16'h0000);
            cell_words_due.push_back(expand_cells(v[15:8], 8'h00, 1'b0, 1'b0));
            cell_words_due.push_back(expand_cells(v[7:0], 8'h00, 1'b0, 1'b1));
        end else begin
            cell_words_due.push_back(expand_cells(it.data_byte, it.clock_byte,
                                                  it.action == ACT_MARK, 1'b1));
            if (it.crc_update)
                crc_state = crc16_ccitt_byte(crc_state, it.data_byte);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer, then pick the next ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_side
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cell_words_due.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result: expected none, actual %h", $time, o_out);
            end else begin
                want = cell_words_due.pop_front();
                if (o_out.cells !== want.cells) begin
                    mismatch_count++;
                    $display("%0t cells: expected %h, actual %h", $time,
                             want.cells, o_out.cells);
                end
                if (o_out.cell_count !== want.cell_count) begin
                    mismatch_count++;
                    $display("%0t cell_count: expected %0d, actual %0d", $time,
                             want.cell_count, o_out.cell_count);
                end
                if (o_out.last_of_item !== want.last_of_item) begin
                    mismatch_count++;
                    $display("%0t last_of_item: expected %b, actual %b", $time,
                             want.last_of_item, o_out.last_of_item);
                end
            end
        end
        // Drop ready at random, about a fifth of the time, unless a calm stretch is running
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    function automatic t_in_item make_item(logic [1:0] act, logic [7:0] d, logic [7:0] c,
                                           logic ld, logic [15:0] seed, logic upd,
                                           logic spoil);
        t_in_item it;
        it.action      = act;
        it.data_byte   = d;
        it.clock_byte  = c;
        it.crc_load    = ld;
        it.crc_seed    = seed;
        it.crc_update  = upd;
        it.corrupt_crc = spoil;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return make_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 1'($urandom),
                         16'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Send one item: idle at random first, then hold valid until the transfer.
    // Leave valid high on exit so a following item goes out back to back.
    task automatic send_item(t_in_item it);
        while (!calm && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            i_in       <= random_item();
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_cells(it);
        if (it.action != ACT_NONE)
            real_sent++;
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (cell_words_due.size() != 0);
    endtask

    // Write the encoding mode while the block is idle
    task automatic write_mode(logic m);
        hold_until_drained();
        // Allow for ignored items still in flight
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_reg = m;
    endtask

    // One sector-style record: sync marks, address mark, payload, CRC.
    // Some records are broken on purpose: no CRC seed, no CRC out, skipped updates.
    task automatic send_record();
        logic        fm;
        logic        broken;
        logic [7:0]  am;
        int          nmarks;
        int          nbytes;
        int          i;
        fm     = (mode_reg == MODE_FM);
        broken = ($urandom_range(99) < 15);
        case ($urandom_range(3))
            0: am = 8'hFE;
            1: am = 8'hFB;
            2: am = 8'hF8;
            default: am = 8'hFC;
        endcase
        if (fm) begin
            send_item(make_item(ACT_MARK, am, (am == 8'hFC) ? 8'hD7 : 8'hC7,
                                !(broken && $urandom_range(1)), 16'hFFFF, 1'b1,
                                1'($urandom)));
        end else begin
            nmarks = $urandom_range(3, 1);
            for (i = 0; i < nmarks; i++) begin
                send_item(make_item(ACT_MARK, 8'hA1, 8'h0A,
                                    (i == 0) && !(broken && $urandom_range(1)),
                                    16'hFFFF, 1'b1, 1'($urandom)));
            end
            send_item(make_item(ACT_DATA, am, 8'($urandom), 1'b0, 16'($urandom), 1'b1,
                                1'($urandom)));
        end
        nbytes = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        for (i = 0; i < nbytes; i++) begin
            send_item(make_item(ACT_DATA, 8'($urandom), 8'($urandom), 1'b0, 16'($urandom),
                                broken ? 1'($urandom_range(1)) : 1'b1, 1'($urandom)));
        end
        if (!(broken && $urandom_range(1)))
            send_item(make_item(ACT_CRC, 8'($urandom), 8'($urandom), 1'b0, 16'($urandom),
                                1'($urandom), $urandom_range(9) == 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // MFM out of reset: byte extremes, sync marks, CRC out and its variants
    task automatic test_mfm_after_reset();
        send_item(make_item(ACT_DATA, 8'h00, 8'hFF, 1'b0, 16'h0000, 1'b1, 1'b1));
        send_item(make_item(ACT_DATA, 8'hFF, 8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b0));
        send_item(make_item(ACT_DATA, 8'h55, 8'hAA, 1'b0, 16'h0000, 1'b0, 1'b0));
        // Three missing-clock sync marks from a fresh seed; CRC then reads CDB4
        send_item(make_item(ACT_MARK, 8'hA1, 8'h0A, 1'b1, 16'hFFFF, 1'b1, 1'b0));
        send_item(make_item(ACT_MARK, 8'hA1, 8'h0A, 1'b0, 16'h0000, 1'b1, 1'b0));
        send_item(make_item(ACT_MARK, 8'hA1, 8'h0A, 1'b0, 16'h0000, 1'b1, 1'b0));
        send_item(make_item(ACT_DATA, 8'hFE, 8'h00, 1'b0, 16'h0000, 1'b1, 1'b0));
        // CRC out ignores the update request
        send_item(make_item(ACT_CRC, 8'hFF, 8'hFF, 1'b0, 16'h0000, 1'b1, 1'b0));
        // Load before CRC out, and spoil it
        send_item(make_item(ACT_CRC, 8'h00, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b1));
        // Unused action: load and update must have no effect
        send_item(make_item(ACT_NONE, 8'hAA, 8'h55, 1'b1, 16'h1234, 1'b1, 1'b1));
        send_item(make_item(ACT_CRC, 8'h00, 8'h00, 1'b0, 16'hFFFF, 1'b0, 1'b0));
    endtask

    // FM marks with their missing clocks, then CRC out
    task automatic test_fm_marks();
        write_mode(MODE_FM);
        send_item(make_item(ACT_MARK, 8'hFE, 8'hC7, 1'b1, 16'hFFFF, 1'b1, 1'b0));
        send_item(make_item(ACT_MARK, 8'hFC, 8'hD7, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(ACT_DATA, 8'hAA, 8'h00, 1'b0, 16'h0000, 1'b1, 1'b0));
        send_item(make_item(ACT_CRC, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1));
        send_item(make_item(ACT_CRC, 8'h00, 8'h00, 1'b1, 16'hFFFF, 1'b0, 1'b0));
    endtask

    // Back to MFM: index mark and its clock pattern
    task automatic test_mfm_index_mark();
        write_mode(MODE_MFM);
        send_item(make_item(ACT_MARK, 8'hC2, 8'h14, 1'b1, 16'hFFFF, 1'b1, 1'b0));
        send_item(make_item(ACT_DATA, 8'hFF, 8'hFF, 1'b0, 16'h0000, 1'b1, 1'b0));
        send_item(make_item(ACT_CRC, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0));
    endtask

    // Let the sender wait out every owed result, then resume
    task automatic test_drain_pause();
        send_record();
        hold_until_drained();
        send_record();
    endtask

    // One random phase in a given mode, with records, noise and pauses
    task automatic random_phase(logic m, int n, bit quiet);
        int start;
        int r;
        write_mode(m);
        calm  = quiet;
        start = real_sent;
        while (real_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 70)
                send_record();
            else if (r < 98)
                send_item(random_item());
            else
                hold_until_drained();
        end
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(MODE_FM, 145, 1'b0);
        random_phase(MODE_MFM, 145, 1'b0);
        random_phase(MODE_FM, 145, 1'b1);
        random_phase(MODE_MFM, 145, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        mode_reg      = MODE_MFM;
        crc_state     = CRC_RESET;
        prev_data_bit = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mfm_after_reset();
        test_fm_marks();
        test_mfm_index_mark();
        test_drain_pause();
        test_random_traffic();

        // Drain, then keep the clock running so any stray result would still show
        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #RUN_LIMIT;
        $display("tb: failure");
        $finish;
    end

endmodule
